@@ sv/ahfr_pkg.sv @@
// package for the ascii hex frame receiver: types, codes, constants and the nibble rule
// used by every module of the block except the generic queue; depends on nothing
`default_nettype none

package ahfr_pkg;

   // frame delimiters
   localparam logic [7:0] SOF_CHAR = 8'h7E;
   localparam logic [7:0] EOF_CHAR = 8'h0D;

   // default frame length limit in characters, and the width of the character counter
   localparam int MAX_FRAME_CHARS_DEF = 2048;
   localparam int CHAR_COUNT_W        = 12;

   // depth of the request queue and of the result queue
   localparam int QUEUE_DEPTH = 2;

   // timeout register reset value and the configuration register index
   localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd150;
   localparam logic        REG_IDLE_TIMEOUT   = 1'b0;

   // request classes produced by the front end
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SOF  = 2'd1,
      OP_EOF  = 2'd2,
      OP_BODY = 2'd3
   } op_code_type;

   // report codes
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_START = 3'd1,
      ST_OVERSIZE  = 3'd2,
      ST_CHECKSUM  = 3'd3,
      ST_TOO_SHORT = 3'd4,
      ST_DEV_ERROR = 3'd5,
      ST_TIMEOUT   = 3'd6
   } status_type;

   // classified request, front to back
   typedef struct packed {
      op_code_type op;
      logic [7:0]  ch;
   } op_type;

   // one result item
   typedef struct packed {
      logic       is_end;
      logic [7:0] data_byte;
      logic [9:0] byte_index;
      status_type status;
      logic [7:0] device_error;
      logic [7:0] source_address;
   } result_type;

   // unchecked nibble rule: digits by subtraction, anything else by the low three bits
   function automatic logic [7:0] nib(input logic [7:0] c);
      logic [7:0] r;
      if (c <= 8'h39) r = c - 8'h30;
      else            r = {5'd0, c[2:0]} + 8'd9;
      return r;
   endfunction

   // pair of characters to one byte, high nibble keeps only its low four bits
   function automatic logic [7:0] hexpair(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] na;
      na = nib(a);
      return {na[3:0], 4'd0} + nib(b);
   endfunction

endpackage

`default_nettype wire

@@ sv/ahfr_fifo.sv @@
// small register queue with a first-word-fall-through head
// generic in width and depth; depends on nothing
`default_nettype none

module ahfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/ahfr_front.sv @@
// front end: accepts requests, classifies them and queues them for the back end
// depends on ahfr_pkg and ahfr_fifo
`default_nettype none

module ahfr_front
   import ahfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_rx_char,
   output op_type          op,
   output logic            op_valid,
   input  wire logic       op_pop
);

   op_type cls;
   logic   op_empty;
   logic [$bits(op_type)-1:0] head_bits;

   // classify the request: tick, frame start, frame end or plain character
   always_comb begin
      cls.ch = req_rx_char;
      if (req_kind) begin
         cls.op = OP_TICK;
      end else if (req_rx_char == SOF_CHAR) begin
         cls.op = OP_SOF;
      end else if (req_rx_char == EOF_CHAR) begin
         cls.op = OP_EOF;
      end else begin
         cls.op = OP_BODY;
      end
   end

   // request queue between front and back
   ahfr_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cls),
      .full    (full),
      .rd_en   (op_pop),
      .rd_data (head_bits),
      .empty   (op_empty)
   );

   assign op       = op_type'(head_bits);
   assign op_valid = !op_empty;

endmodule

`default_nettype wire

@@ sv/ahfr_back.sv @@
// back end: frame state, lookahead, checksum, pair decoding and reports, with the result queue
// depends on ahfr_pkg and ahfr_fifo
`default_nettype none

module ahfr_back
   import ahfr_pkg::*;
#(
   parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] idle_timeout,
   input  wire op_type      op,
   input  wire logic        op_valid,
   output logic             op_pop,
   output result_type       rsp,
   output logic             empty,
   input  wire logic        pop
);

   localparam logic [CHAR_COUNT_W-1:0] MAX_CHARS = CHAR_COUNT_W'(MAX_FRAME_CHARS);

   logic                    in_frame_ff,   in_frame_in;
   logic [CHAR_COUNT_W-1:0] char_count_ff, char_count_in;
   logic [15:0]             sum_ff,        sum_in;
   logic [7:0]              look_ff [4];
   logic [7:0]              look_in [4];
   logic [3:0]              hi_nib_ff,     hi_nib_in;
   logic [9:0]              dec_count_ff,  dec_count_in;
   logic [7:0]              err_ff,        err_in;
   logic [7:0]              addr_ff,       addr_in;
   logic [15:0]             idle_ff,       idle_in;
   logic                    long_ff,       long_in;

   logic        go;
   logic        res_full;
   logic        res_valid;
   result_type  res;
   logic [15:0] idle_inc;
   logic [15:0] want;
   logic [15:0] got;
   logic [7:0]  old_nib;
   logic [7:0]  dec_byte;
   logic [$bits(result_type)-1:0] rsp_bits;

   assign go      = op_valid && !res_full;
   assign op_pop  = go;
   assign idle_inc = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign want    = ~sum_ff + 16'd1;
   assign got     = {hexpair(look_ff[0], look_ff[1]), hexpair(look_ff[2], look_ff[3])};
   assign old_nib = nib(look_ff[0]);
   assign dec_byte = {hi_nib_ff, 4'd0} + old_nib;

   // execute one request
   always_comb begin
      in_frame_in   = in_frame_ff;
      char_count_in = char_count_ff;
      sum_in        = sum_ff;
      look_in       = look_ff;
      hi_nib_in     = hi_nib_ff;
      dec_count_in  = dec_count_ff;
      err_in        = err_ff;
      addr_in       = addr_ff;
      idle_in       = idle_ff;
      long_in       = long_ff;
      res_valid     = 1'b0;
      res           = '0;
      res.status    = ST_OK;

      if (go) begin
         unique case (op.op) inside
            OP_TICK: begin
               // idle timer, drops a partial frame when it runs past the limit
               if (idle_inc > idle_timeout) begin
                  idle_in = '0;
                  if (in_frame_ff) begin
                     in_frame_in = 1'b0;
                     res_valid   = 1'b1;
                     res.is_end  = 1'b1;
                     res.status  = ST_TIMEOUT;
                  end
               end else begin
                  idle_in = idle_inc;
               end
            end
            OP_SOF, OP_EOF, OP_BODY: begin
               if (!in_frame_ff) begin
                  // hunting for a frame start
                  if (op.op == OP_SOF) begin
                     in_frame_in   = 1'b1;
                     char_count_in = CHAR_COUNT_W'(1);
                     sum_in        = '0;
                     look_in       = '{default: 8'd0};
                     hi_nib_in     = '0;
                     dec_count_in  = '0;
                     err_in        = '0;
                     addr_in       = '0;
                     long_in       = 1'b0;
                     idle_in       = '0;
                  end else begin
                     res_valid  = 1'b1;
                     res.is_end = 1'b1;
                     res.status = ST_BAD_START;
                  end
               end else if (op.op == OP_EOF) begin
                  // frame end report
                  in_frame_in = 1'b0;
                  res_valid   = 1'b1;
                  res.is_end  = 1'b1;
                  if (long_ff) begin
                     res.status = ST_OVERSIZE;
                  end else if (want != got) begin
                     res.status = ST_CHECKSUM;
                  end else if (dec_count_ff < 10'd8) begin
                     res.status = ST_TOO_SHORT;
                  end else if (err_ff != 8'd0) begin
                     res.status       = ST_DEV_ERROR;
                     res.device_error = err_ff;
                  end else begin
                     res.status         = ST_OK;
                     res.source_address = addr_ff;
                  end
               end else begin
                  // body character through the lookahead
                  idle_in = '0;
                  if (long_ff || char_count_ff >= MAX_CHARS) begin
                     long_in = 1'b1;
                  end else begin
                     char_count_in = char_count_ff + 1'b1;
                     look_in[0]    = look_ff[1];
                     look_in[1]    = look_ff[2];
                     look_in[2]    = look_ff[3];
                     look_in[3]    = op.ch;
                     if (char_count_ff >= CHAR_COUNT_W'(5)) begin
                        sum_in = sum_ff + {8'd0, look_ff[0]};
                        if (char_count_ff[0]) begin
                           hi_nib_in = old_nib[3:0];
                        end else if (dec_count_ff != 10'h3FF) begin
                           if (dec_count_ff == 10'd3) begin
                              err_in = dec_byte;
                           end
                           if (dec_count_ff == 10'd7) begin
                              addr_in = dec_byte;
                           end
                           dec_count_in   = dec_count_ff + 10'd1;
                           res_valid      = 1'b1;
                           res.data_byte  = dec_byte;
                           res.byte_index = dec_count_ff;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         char_count_ff <= '0;
         sum_ff        <= '0;
         look_ff       <= '{default: 8'd0};
         hi_nib_ff     <= '0;
         dec_count_ff  <= '0;
         err_ff        <= '0;
         addr_ff       <= '0;
         idle_ff       <= '0;
         long_ff       <= 1'b0;
      end else begin
         in_frame_ff   <= in_frame_in;
         char_count_ff <= char_count_in;
         sum_ff        <= sum_in;
         look_ff       <= look_in;
         hi_nib_ff     <= hi_nib_in;
         dec_count_ff  <= dec_count_in;
         err_ff        <= err_in;
         addr_ff       <= addr_in;
         idle_ff       <= idle_in;
         long_ff       <= long_in;
      end
   end

   // result queue toward the consumer
   ahfr_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (rsp_bits),
      .empty   (empty)
   );

   assign rsp = result_type'(rsp_bits);

endmodule

`default_nettype wire

@@ sv/ascii_hex_frame_receiver_top.sv @@
// top level of the ascii hex frame receiver: register port and the front and back ends
// depends on ahfr_pkg, ahfr_front and ahfr_back
//
// Requests enter through push/full: req_kind 0 carries a received character in req_rx_char,
// req_kind 1 is a one millisecond tick. Results leave through empty/pop: either a decoded
// data byte with its index in the frame, or an end report (status, device error code,
// source address). A frame opens at 0x7E and closes at 0x0D; the last four hex characters
// are the checksum.
// Throughput is one request per cycle while the result queue has room. When both queues are
// empty, an accepted request shows at the head of the request queue, the back end's state
// update writes its result into the result queue, and from there it is on the rsp_ ports.
// Each request produces at most one result. When pop stays low the result queue fills, the
// back end stops, the request queue fills behind it and full rises after two more requests.
// Reset (synchronous) empties both queues, leaves the receiver out of frame, clears the idle
// timer and sets idle_timeout_ms to 150. The timeout register sits at byte address 0. The
// user must write it only while no request is in flight; the block does not enforce this.
`default_nettype none

module ascii_hex_frame_receiver_top
   import ahfr_pkg::*;
#(
   parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_rx_char,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_is_end,
   output logic [7:0]       rsp_data_byte,
   output logic [9:0]       rsp_byte_index,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_device_error,
   output logic [7:0]       rsp_source_address,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0] timeout_ff, timeout_in;
   logic        csr_wr;
   op_type      op;
   logic        op_valid;
   logic        op_pop;
   result_type  rsp;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_wr && paddr[2] == REG_IDLE_TIMEOUT) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_IDLE_TIMEOUT) begin
         prdata = {16'd0, timeout_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= IDLE_TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   ahfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_kind    (req_kind),
      .req_rx_char (req_rx_char),
      .op          (op),
      .op_valid    (op_valid),
      .op_pop      (op_pop)
   );

   ahfr_back #(
      .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .idle_timeout (timeout_ff),
      .op           (op),
      .op_valid     (op_valid),
      .op_pop       (op_pop),
      .rsp          (rsp),
      .empty        (empty),
      .pop          (pop)
   );

   // result fields
   assign rsp_is_end         = rsp.is_end;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_byte_index     = rsp.byte_index;
   assign rsp_status         = rsp.status;
   assign rsp_device_error   = rsp.device_error;
   assign rsp_source_address = rsp.source_address;

endmodule

`default_nettype wire

@@ verif/ascii_hex_frame_receiver_checker.sv @@
// checker for the ascii hex frame receiver: follows accepted requests and register writes,
// predicts each result and compares it with what the receiver side pops
// depends on ahfr_pkg for the result layout, status codes and delimiters
`timescale 1ns / 1ps

module ascii_hex_frame_receiver_checker
   import ahfr_pkg::*;
#(
   parameter int MAX_CHARS = MAX_FRAME_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_char,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_is_end,
   input  logic [7:0]  rsp_data_byte,
   input  logic [9:0]  rsp_byte_index,
   input  logic [2:0]  rsp_status,
   input  logic [7:0]  rsp_device_error,
   input  logic [7:0]  rsp_source_address,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending,
   output int          results_checked,
   output int          frames_accepted
);

   localparam logic [2:0] TIMEOUT_ADDR = {REG_IDLE_TIMEOUT, 2'b00};

   // predicted receiver state
   logic        frame_open;
   int unsigned next_pos;
   logic [15:0] char_sum;
   logic [7:0]  window [4];
   logic [7:0]  high_nib;
   int unsigned byte_count;
   logic [7:0]  error_byte;
   logic [7:0]  address_byte;
   logic [15:0] idle_ticks;
   logic        too_long;
   logic [15:0] timeout_ms;

   result_type  expected_results [$];
   int          errors = 0;
   int          checked = 0;
   int          accepted = 0;

   initial begin
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      frames_accepted = 0;
   end

   // unchecked hex digit rule: digits by subtraction, the rest by the low three bits
   function automatic logic [7:0] hex_nibble(input logic [7:0] c);
      if (c <= 8'h39) return c - 8'h30;
      return (c & 8'h07) + 8'd9;
   endfunction

   function automatic logic [7:0] hex_byte(input logic [7:0] a, input logic [7:0] b);
      return (hex_nibble(a) << 4) + hex_nibble(b);
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("end=%0d byte=%02h index=%0d status=%0d error=%02h address=%02h",
                       r.is_end, r.data_byte, r.byte_index, r.status, r.device_error,
                       r.source_address);
   endfunction

   // advance the predicted state by one request, queue the result it causes
   task automatic predict_request(input logic kind, input logic [7:0] c);
      result_type  r;
      logic        produced;
      logic [7:0]  leaving;
      logic [7:0]  value;
      logic [15:0] want_sum;
      logic [15:0] got_sum;
      int unsigned pos;
      r        = '0;
      r.status = ST_OK;
      produced = 1'b0;
      if (kind) begin
         // millisecond tick: saturating idle count, timeout drops a partial frame
         if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
         if (idle_ticks > timeout_ms) begin
            idle_ticks = '0;
            if (frame_open) begin
               frame_open = 1'b0;
               r.is_end   = 1'b1;
               r.status   = ST_TIMEOUT;
               produced   = 1'b1;
            end
         end
      end else if (!frame_open) begin
         // outside a frame only the start character is welcome
         if (c != SOF_CHAR) begin
            r.is_end = 1'b1;
            r.status = ST_BAD_START;
            produced = 1'b1;
         end else begin
            frame_open   = 1'b1;
            next_pos     = 1;
            char_sum     = '0;
            window       = '{default: 8'h00};
            high_nib     = '0;
            byte_count   = 0;
            error_byte   = '0;
            address_byte = '0;
            too_long     = 1'b0;
            idle_ticks   = '0;
         end
      end else if (c == EOF_CHAR) begin
         // frame end: report in priority order
         frame_open = 1'b0;
         r.is_end   = 1'b1;
         produced   = 1'b1;
         want_sum   = ~char_sum + 16'd1;
         got_sum    = {hex_byte(window[0], window[1]), hex_byte(window[2], window[3])};
         if (too_long) begin
            r.status = ST_OVERSIZE;
         end else if (want_sum != got_sum) begin
            r.status = ST_CHECKSUM;
         end else if (byte_count < 8) begin
            r.status = ST_TOO_SHORT;
         end else if (error_byte != 8'h00) begin
            r.status       = ST_DEV_ERROR;
            r.device_error = error_byte;
         end else begin
            r.status         = ST_OK;
            r.source_address = address_byte;
         end
      end else begin
         idle_ticks = '0;
         if (too_long || next_pos >= MAX_CHARS) begin
            too_long = 1'b1;
         end else begin
            // shift through the lookahead, the leaving character is body
            pos       = next_pos;
            next_pos  = next_pos + 1;
            leaving   = window[0];
            window[0] = window[1];
            window[1] = window[2];
            window[2] = window[3];
            window[3] = c;
            if (pos >= 5) begin
               char_sum = char_sum + {8'd0, leaving};
               if (((pos - 4) & 1) != 0) begin
                  high_nib = hex_nibble(leaving) & 8'h0F;
               end else if (byte_count < 1023) begin
                  value = (high_nib << 4) + hex_nibble(leaving);
                  if (byte_count == 3) error_byte = value;
                  if (byte_count == 7) address_byte = value;
                  r.data_byte  = value;
                  r.byte_index = 10'(byte_count);
                  byte_count   = byte_count + 1;
                  produced     = 1'b1;
               end
            end
         end
      end
      if (produced) expected_results = {expected_results, r};
   endtask

   always @(posedge clock) begin : watch
      result_type seen;
      result_type want;
      if (reset) begin
         frame_open   = 1'b0;
         next_pos     = 0;
         char_sum     = '0;
         window       = '{default: 8'h00};
         high_nib     = '0;
         byte_count   = 0;
         error_byte   = '0;
         address_byte = '0;
         idle_ticks   = '0;
         too_long     = 1'b0;
         timeout_ms   = IDLE_TIMEOUT_RESET;
         expected_results.delete();
      end else begin
         // result popped at this edge against the oldest prediction
         if (pop && !empty) begin
            seen.is_end         = rsp_is_end;
            seen.data_byte      = rsp_data_byte;
            seen.byte_index     = rsp_byte_index;
            seen.status         = status_type'(rsp_status);
            seen.device_error   = rsp_device_error;
            seen.source_address = rsp_source_address;
            if (expected_results.size() == 0) begin
               errors = errors + 1;
               $display("%0t: unexpected result, expected none, actual %s", $time,
                        describe(seen));
            end else begin
               want    = expected_results.pop_front();
               checked = checked + 1;
               if (want.is_end && want.status == ST_OK) accepted = accepted + 1;
               if (seen.is_end !== want.is_end || seen.data_byte !== want.data_byte ||
                   seen.byte_index !== want.byte_index || seen.status !== want.status ||
                   seen.device_error !== want.device_error ||
                   seen.source_address !== want.source_address) begin
                  errors = errors + 1;
                  $display("%0t: result mismatch, expected %s, actual %s", $time,
                           describe(want), describe(seen));
               end
            end
         end
         // register writes and read-back
         if (psel && penable && pready && paddr == TIMEOUT_ADDR) begin
            if (pwrite) begin
               timeout_ms = pwdata[15:0];
            end else if (prdata !== {16'd0, timeout_ms}) begin
               errors = errors + 1;
               $display("%0t: timeout register read, expected %08h, actual %08h", $time,
                        {16'd0, timeout_ms}, prdata);
            end
         end
         // request accepted at this edge
         if (push && !full) predict_request(req_kind, req_rx_char);
      end
      fail_count      <= errors;
      pending         <= expected_results.size();
      results_checked <= checked;
      frames_accepted <= accepted;
   end

endmodule

@@ verif/ascii_hex_frame_receiver_top_test.sv @@
// top of the ascii hex frame receiver regression: clock, reset, request and register
// stimulus under several idle patterns; the checker beside the block decides pass or fail
// depends on ahfr_pkg, ascii_hex_frame_receiver_top and ascii_hex_frame_receiver_checker
`timescale 1ns / 1ps

module ascii_hex_frame_receiver_top_test;
   import ahfr_pkg::*;

   localparam int FRAME_LIMIT   = MAX_FRAME_CHARS_DEF;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_LIMIT   = 20_000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic [2:0] TIMEOUT_ADDR = {REG_IDLE_TIMEOUT, 2'b00};
   localparam logic       REQ_CHAR     = 1'b0;
   localparam logic       REQ_TICK     = 1'b1;

   // ways a generated frame departs from a clean one
   typedef enum int {
      FLAW_NONE,
      FLAW_TICKS,
      FLAW_DEV_ERROR,
      FLAW_CHECKSUM,
      FLAW_ODD,
      FLAW_NOISE
   } flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        req_kind = 1'b0;
   logic [7:0]  req_rx_char = 8'h00;
   logic        pop = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;

   logic        full;
   logic        empty;
   logic        rsp_is_end;
   logic [7:0]  rsp_data_byte;
   logic [9:0]  rsp_byte_index;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_device_error;
   logic [7:0]  rsp_source_address;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count;
   int          pending;
   int          results_checked;
   int          frames_accepted;

   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;

   ascii_hex_frame_receiver_top #(
      .MAX_FRAME_CHARS(FRAME_LIMIT)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_kind           (req_kind),
      .req_rx_char        (req_rx_char),
      .empty              (empty),
      .pop                (pop),
      .rsp_is_end         (rsp_is_end),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_status         (rsp_status),
      .rsp_device_error   (rsp_device_error),
      .rsp_source_address (rsp_source_address),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   ascii_hex_frame_receiver_checker #(
      .MAX_CHARS(FRAME_LIMIT)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_kind           (req_kind),
      .req_rx_char        (req_rx_char),
      .empty              (empty),
      .pop                (pop),
      .rsp_is_end         (rsp_is_end),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_status         (rsp_status),
      .rsp_device_error   (rsp_device_error),
      .rsp_source_address (rsp_source_address),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .pending            (pending),
      .results_checked    (results_checked),
      .frames_accepted    (frames_accepted)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
         $display("ascii_hex_frame_receiver_top regression: fail");
         $finish;
      end
   end

   // result side: pop with random stalls
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else       pop <= ($urandom_range(0, 99) >= stall_pct);
   end

   // hex digit in either letter case
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + {4'd0, n};
      if ($urandom_range(0, 1) == 0) return 8'h37 + {4'd0, n};
      return 8'h57 + {4'd0, n};
   endfunction

   // any character that does not close a frame
   function automatic logic [7:0] random_body_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == EOF_CHAR) c = 8'h00;
      return c;
   endfunction

   // one request through push/full, with random gaps before it
   task automatic send_item(input logic kind, input logic [7:0] c);
      while ($urandom_range(0, 99) < gap_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_kind    <= kind;
      req_rx_char <= c;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent = items_sent + 1;
   endtask

   // start character, hex body of n_bytes altered by the flaw, four checksum characters, carriage return
   task automatic send_frame(input int unsigned n_bytes, input flaw_type flaw);
      logic [7:0]  body [$];
      logic [7:0]  tail [4];
      logic [7:0]  value;
      logic [15:0] sum;
      logic [15:0] check_value;
      int unsigned i;
      sum = '0;
      for (i = 0; i < n_bytes; i++) begin
         value = 8'($urandom_range(0, 255));
         if (i == 3) value = (flaw == FLAW_DEV_ERROR) ? 8'($urandom_range(1, 255)) : 8'h00;
         body = {body, hex_char(value[7:4])};
         body = {body, hex_char(value[3:0])};
      end
      if (flaw == FLAW_ODD) body = {body, hex_char(4'($urandom_range(0, 15)))};
      if (flaw == FLAW_NOISE) begin
         foreach (body[j]) begin
            if ($urandom_range(0, 7) == 0) body[j] = random_body_char();
         end
      end
      foreach (body[j]) sum = sum + {8'd0, body[j]};
      check_value = ~sum + 16'd1;
      if (flaw == FLAW_CHECKSUM) check_value = check_value + 16'($urandom_range(1, 65535));
      tail[0] = hex_char(check_value[15:12]);
      tail[1] = hex_char(check_value[11:8]);
      tail[2] = hex_char(check_value[7:4]);
      tail[3] = hex_char(check_value[3:0]);
      if (flaw == FLAW_CHECKSUM && $urandom_range(0, 3) == 0)
         tail[2'($urandom_range(0, 3))] = random_body_char();
      send_item(REQ_CHAR, SOF_CHAR);
      foreach (body[j]) begin
         if (flaw == FLAW_TICKS && $urandom_range(0, 9) == 0)
            send_item(REQ_TICK, 8'($urandom_range(0, 255)));
         send_item(REQ_CHAR, body[j]);
      end
      for (i = 0; i < 4; i++) send_item(REQ_CHAR, tail[i]);
      send_item(REQ_CHAR, EOF_CHAR);
   endtask

   // stop requests, wait for every predicted result, then let the pipeline settle
   task automatic drain();
      int unsigned w;
      push <= 1'b0;
      @(posedge clock);
      for (w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register access: setup cycle, then access cycle until pready
   task automatic csr_access(input logic wr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= TIMEOUT_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_start;
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      int unsigned i;
      int unsigned burst;
      logic [7:0]  c;
      logic [15:0] timeout_setting;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the timeout register
      csr_access(1'b0, 32'd0);
      timeout_setting = IDLE_TIMEOUT_RESET;

      // directed: empty frame, bad starts incl. carriage return, a tick, a clean frame
      send_item(REQ_CHAR, SOF_CHAR);
      send_item(REQ_CHAR, EOF_CHAR);
      send_item(REQ_CHAR, EOF_CHAR);
      send_item(REQ_CHAR, 8'h00);
      send_item(REQ_CHAR, 8'hFF);
      send_item(REQ_TICK, 8'hFF);
      send_frame(8, FLAW_NONE);

      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       timeout_setting = IDLE_TIMEOUT_RESET;
            1:       timeout_setting = 16'd0;
            2:       timeout_setting = 16'hFFFF;
            3:       timeout_setting = 16'd3;
            4:       timeout_setting = 16'd1;
            5:       timeout_setting = 16'($urandom_range(4, 40));
            6:       timeout_setting = 16'd200;
            default: timeout_setting = 16'd2;
         endcase
         csr_access(1'b1, {16'd0, timeout_setting});
         csr_access(1'b0, 32'd0);

         // idle pattern of this phase
         case (phase % 4)
            0: begin
               gap_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               gap_pct = 84;
               stall_pct <= 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct <= 84;
            end
            default: begin
               gap_pct = 22;
               stall_pct <= 22;
            end
         endcase

         // a random mix of well-formed frames, broken ones, strays, timeouts and noise
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 20);
            if (pick < 46) begin
               send_frame(n, ($urandom_range(0, 9) == 0) ? FLAW_TICKS : FLAW_NONE);
            end else if (pick < 54) begin
               send_frame(n, FLAW_DEV_ERROR);
            end else if (pick < 62) begin
               send_frame(n, FLAW_CHECKSUM);
            end else if (pick < 70) begin
               send_frame(n, FLAW_ODD);
            end else if (pick < 78) begin
               send_frame(n, FLAW_NOISE);
            end else if (pick < 83) begin
               // stray characters outside a frame
               k = $urandom_range(1, 3);
               for (i = 0; i < k; i++) begin
                  case ($urandom_range(0, 3))
                     0:       c = EOF_CHAR;
                     1:       c = 8'h00;
                     2:       c = 8'hFF;
                     default: c = 8'($urandom_range(0, 255));
                  endcase
                  if (c == SOF_CHAR) c = EOF_CHAR;
                  send_item(REQ_CHAR, c);
               end
            end else if (pick < 89) begin
               // partial frame left to time out, unless the timeout setting is 250 or more
               send_item(REQ_CHAR, SOF_CHAR);
               k = $urandom_range(0, 6);
               for (i = 0; i < k; i++) send_item(REQ_CHAR, hex_char(4'($urandom_range(0, 15))));
               if (timeout_setting < 16'd250)
                  burst = timeout_setting + 1 + $urandom_range(0, 2);
               else
                  burst = $urandom_range(1, 20);
               for (i = 0; i < burst; i++) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
               // frame shorter than its checksum
               send_item(REQ_CHAR, SOF_CHAR);
               k = $urandom_range(0, 3);
               for (i = 0; i < k; i++) send_item(REQ_CHAR, hex_char(4'($urandom_range(0, 15))));
               send_item(REQ_CHAR, EOF_CHAR);
            end else begin
               // raw requests of any kind and value
               k = $urandom_range(1, 6);
               for (i = 0; i < k; i++)
                  send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end
      end

      drain();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (pending != 0)
         $display("%0t: %0d expected results never arrived", $time, pending);
      $display("sent %0d requests over %0d timeout and idle settings", items_sent, PHASES);
      $display("checked %0d results, %0d frames reported ok", results_checked,
               frames_accepted);
      if (fail_count == 0 && pending == 0)
         $display("ascii_hex_frame_receiver_top regression: pass");
      else
         $display("ascii_hex_frame_receiver_top regression: fail");
      $finish;
   end

endmodule

@@ ascii_hex_frame_receiver_top.f @@
sv/ahfr_pkg.sv
sv/ahfr_fifo.sv
sv/ahfr_front.sv
sv/ahfr_back.sv
sv/ascii_hex_frame_receiver_top.sv
verif/ascii_hex_frame_receiver_checker.sv
verif/ascii_hex_frame_receiver_top_test.sv
